// ----- rtl/additive_lagged_fibonacci_rng_macros.svh -----
// Assertion macros for the lagged-Fibonacci generator.
// Used by additive_lagged_fibonacci_rng.sv; expects clk_i and rst_ni in scope.
`ifndef ADDITIVE_LAGGED_FIBONACCI_RNG_MACROS_SVH
`define ADDITIVE_LAGGED_FIBONACCI_RNG_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ALFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ALFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/alfr_pkg.sv -----
// Shared constants and types of the lagged-Fibonacci generator.
// No dependencies; imported by additive_lagged_fibonacci_rng and its bench.
package alfr_pkg;

  localparam int unsigned LAG_DEGREE     = 31;
  localparam int unsigned LAG_SEPARATION = 3;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned OUT_W          = 31;
  localparam int unsigned IDX_W          = $clog2(LAG_DEGREE);

  // Reseed discards this many draws.
  localparam int unsigned DISCARD_COUNT  = 10 * LAG_DEGREE;
  localparam int unsigned DISC_W         = $clog2(DISCARD_COUNT);

  // Park-Miller minimal standard
  localparam logic [WORD_W-1:0] MINSTD_RED  = 32'h7fff_fffe;
  localparam logic [WORD_W-1:0] MINSTD_MOD  = 32'h7fff_ffff;
  localparam int unsigned       MINSTD_MULT = 16807;
  localparam int unsigned       MULT_W      = 15;
  localparam int unsigned       PROD_W      = OUT_W + MULT_W;

  // Opcodes
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DREAD,
    ST_DRAW,
    ST_RED,
    ST_MUL,
    ST_FOLD,
    ST_WR
  } alfr_state_e;

  // Table contents after reset
  localparam logic [WORD_W-1:0] INIT_WORDS [LAG_DEGREE] = '{
    32'h2cf41758, 32'h27bb3711, 32'h4916d4d1, 32'h7b02f59f, 32'h9b8e28eb, 32'hc0e80269,
    32'h696f5c16, 32'h878f1ff5, 32'h52d9c07f, 32'h916a06cd, 32'hb50b3a20, 32'h2776970a,
    32'hee4eb2a6, 32'he94640ec, 32'hb1d65612, 32'h9d1ed968, 32'h1043f6b7, 32'ha3432a76,
    32'h17eacbb9, 32'h3c09e2eb, 32'h04f8c2b3, 32'h708a1f57, 32'hee341814, 32'h95d0e4d2,
    32'hb06f216c, 32'h8bd2e72e, 32'h8f7c38d7, 32'hcfc6a8fc, 32'h02a59495, 32'ha20d2a69,
    32'he29d12d1
  };

endpackage

// ----- rtl/additive_lagged_fibonacci_rng.sv -----
// Additive lagged-Fibonacci generator (x^31 + x^3 + 1), top level.
// Depends on alfr_pkg, alfr_ram and additive_lagged_fibonacci_rng_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): opcode_i selects a draw or a
//   reseed; seed_value_i is only looked at for a reseed. An item is taken at
//   a rising edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i): one random_value_o item per
//   draw, none per reseed. It sits in an output register, so a new input
//   item can be taken while a result still waits there.
// Timing:
//   Draw: the edge that takes the item also launches the two table reads
//   (front and rear word, one from each RAM copy); in ST_DRAW the block adds
//   them, writes the sum back and loads the output register. A new item is
//   taken only after the previous draw has written its sum back.
//   Reseed: in_stall_o stays high after the item is taken while the block
//   fills 30 table words, each through reduce, multiply, fold and write, and
//   then runs 310 discarded draws.
// Reset: the indices go to 3 and 0 and all table valid bits clear; an entry
//   not yet written reads as its built-in initial word, so there is no
//   clearing pass and the block takes items right after reset.
// Stall: a draw whose result finds the output register still occupied and
//   stalled waits in its execute cycle until the register frees up.
module additive_lagged_fibonacci_rng (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [alfr_pkg::WORD_W-1:0] seed_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [alfr_pkg::OUT_W-1:0]  random_value_o
);

  import alfr_pkg::*;

`include "additive_lagged_fibonacci_rng_macros.svh"

  localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(LAG_DEGREE - 1);
  localparam logic [IDX_W-1:0]  FRONT_RST    = IDX_W'(LAG_SEPARATION);
  localparam logic [IDX_W-1:0]  REAR_RST     = '0;
  localparam logic [IDX_W-1:0]  FIRST_FILL   = IDX_W'(1);
  localparam logic [DISC_W-1:0] DISCARD_LAST = DISC_W'(DISCARD_COUNT - 1);
  localparam logic [IDX_W-1:0]  SEP_WRAP     = IDX_W'(LAG_DEGREE - LAG_SEPARATION);

  // FSM and control state
  alfr_state_e       state_q, state_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [IDX_W-1:0]  rear_q, rear_d;
  logic [IDX_W-1:0]  fill_idx_q, fill_idx_d;
  logic [DISC_W-1:0] disc_cnt_q, disc_cnt_d;
  logic              discard_q, discard_d;
  logic [LAG_DEGREE-1:0] tbl_vld_q, tbl_vld_d;
  logic              out_valid_q, out_valid_d;

  // Datapath registers (no reset)
  logic [WORD_W-1:0] prev_q, prev_d;
  logic [OUT_W-1:0]  x_q, x_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [WORD_W-1:0] fold_q, fold_d;
  logic [OUT_W-1:0]  rand_q, rand_d;

  // Table RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] rd_front, rd_rear;

  logic              in_acc;
  logic              out_free;
  logic [WORD_W-1:0] word_front, word_rear, draw_sum;
  logic [WORD_W-1:0] red_word, fold_mod, seed_word;

  // Input is only taken in idle
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Two copies of the table, written together, each read at one index.
  alfr_ram #(.WIDTH(WORD_W), .DEPTH(LAG_DEGREE)) u_ram_front (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (front_q),
    .rdata_o (rd_front)
  );

  alfr_ram #(.WIDTH(WORD_W), .DEPTH(LAG_DEGREE)) u_ram_rear (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rear_q),
    .rdata_o (rd_rear)
  );

  // Unwritten entries read as their reset word. Valid bits and indices do
  // not move between the read and the execute cycle.
  assign word_front = tbl_vld_q[front_q] ? rd_front : INIT_WORDS[front_q];
  assign word_rear  = tbl_vld_q[rear_q]  ? rd_rear  : INIT_WORDS[rear_q];
  assign draw_sum   = word_front + word_rear;

  // Seed step: prev mod 0x7ffffffe, +1 (prev < 3x modulus)
  always_comb begin
    if (prev_q >= {MINSTD_RED[WORD_W-2:0], 1'b0}) begin
      red_word = prev_q - {MINSTD_RED[WORD_W-2:0], 1'b0};
    end else if (prev_q >= MINSTD_RED) begin
      red_word = prev_q - MINSTD_RED;
    end else begin
      red_word = prev_q;
    end
  end

  // Folded product is below twice 2^31-1 and never equals it
  assign fold_mod  = (fold_q >= MINSTD_MOD) ? (fold_q - MINSTD_MOD) : fold_q;
  assign seed_word = fold_mod - WORD_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (opcode_i == OP_RESEED) ? ST_RED : ST_DRAW;
        end
      end
      ST_DREAD: state_d = ST_DRAW;
      ST_DRAW: begin
        if (discard_q) begin
          state_d = (disc_cnt_q == DISCARD_LAST) ? ST_IDLE : ST_DREAD;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_RED:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_FOLD;
      ST_FOLD: state_d = ST_WR;
      ST_WR:   state_d = (fill_idx_q == LAST_IDX) ? ST_DREAD : ST_RED;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = front_q;
    ram_wdata   = draw_sum;
    ram_re      = 1'b0;
    front_d     = front_q;
    rear_d      = rear_q;
    fill_idx_d  = fill_idx_q;
    disc_cnt_d  = disc_cnt_q;
    discard_d   = discard_q;
    tbl_vld_d   = tbl_vld_q;
    out_valid_d = out_valid_q && out_stall_i;
    prev_d      = prev_q;
    x_d         = x_q;
    prod_d      = prod_q;
    fold_d      = fold_q;
    rand_d      = rand_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_RESEED) begin
            // seed goes straight into word 0
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = seed_value_i;
            tbl_vld_d[0] = 1'b1;
            prev_d     = seed_value_i;
            fill_idx_d = FIRST_FILL;
            discard_d  = 1'b1;
          end else begin
            ram_re    = 1'b1;
            discard_d = 1'b0;
          end
        end
      end
      ST_DREAD: ram_re = 1'b1;
      ST_DRAW: begin
        if (discard_q || out_free) begin
          ram_we             = 1'b1;
          ram_waddr          = front_q;
          ram_wdata          = draw_sum;
          tbl_vld_d[front_q] = 1'b1;
          front_d = (front_q == LAST_IDX) ? '0 : front_q + IDX_W'(1);
          rear_d  = (rear_q == LAST_IDX) ? '0 : rear_q + IDX_W'(1);
          if (discard_q) begin
            disc_cnt_d = disc_cnt_q + DISC_W'(1);
          end else begin
            out_valid_d = 1'b1;
            rand_d      = draw_sum[WORD_W-1:1];
          end
        end
      end
      ST_RED: x_d = red_word[OUT_W-1:0] + OUT_W'(1);
      ST_MUL: prod_d = {{MULT_W{1'b0}}, x_q} * PROD_W'(MINSTD_MULT);
      ST_FOLD: begin
        // 2^31 = 1 modulo 2^31-1
        fold_d = WORD_W'(prod_q[PROD_W-1:OUT_W]) + WORD_W'(prod_q[OUT_W-1:0]);
      end
      ST_WR: begin
        ram_we                = 1'b1;
        ram_waddr             = fill_idx_q;
        ram_wdata             = {1'b0, seed_word[OUT_W-1:0]};
        tbl_vld_d[fill_idx_q] = 1'b1;
        prev_d                = {1'b0, seed_word[OUT_W-1:0]};
        if (fill_idx_q == LAST_IDX) begin
          front_d    = FRONT_RST;
          rear_d     = REAR_RST;
          disc_cnt_d = '0;
        end else begin
          fill_idx_d = fill_idx_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= FRONT_RST;
      rear_q      <= REAR_RST;
      fill_idx_q  <= FIRST_FILL;
      disc_cnt_q  <= '0;
      discard_q   <= 1'b0;
      tbl_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      fill_idx_q  <= fill_idx_d;
      disc_cnt_q  <= disc_cnt_d;
      discard_q   <= discard_d;
      tbl_vld_q   <= tbl_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    x_q    <= x_d;
    prod_q <= prod_d;
    fold_q <= fold_d;
    rand_q <= rand_d;
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = rand_q;

  // Checks
  `ALFR_ASSERT_IMP(a_no_rw_overlap, ram_we, !ram_re, "table read and write in one cycle")
  `ALFR_ASSERT_IMP(a_sep_low, rear_q < SEP_WRAP, front_q == rear_q + FRONT_RST, "lag broken")
  `ALFR_ASSERT_IMP(a_sep_wrap, rear_q >= SEP_WRAP, front_q == rear_q - SEP_WRAP, "lag broken")
  `ALFR_ASSERT_IMP(a_fill_done, state_q == ST_DREAD, &tbl_vld_q, "discard before table filled")
  `ALFR_ASSERT_NXT(a_draw_out, state_q == ST_DRAW && !discard_q && out_free, out_valid_o,
                   "draw result not presented")

endmodule

// ----- rtl/alfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- bench/additive_lagged_fibonacci_rng_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for additive_lagged_fibonacci_rng: draws and reseeds are
// sent from a request queue and every value is checked against a built-in model.
// Depends on alfr_pkg and the RTL of the block.
module additive_lagged_fibonacci_rng_test;
  import alfr_pkg::*;

  localparam int unsigned IDLE_PCT     = 37;      // chance of a gap per cycle, each side
  localparam int unsigned RESEED_PCT   = 3;       // reseeds are slow, keep them rare
  localparam int unsigned STEADY_FROM  = 700;     // window with no idling on either side
  localparam int unsigned STEADY_TO    = 1000;
  localparam int unsigned HOLD_AT      = 300;     // results seen before the long output hold
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Schrage decomposition of the minimal-standard multiplier
  localparam longint SCHRAGE_Q = 127773;
  localparam longint SCHRAGE_R = 2836;

  typedef struct packed {
    logic              opcode;
    logic [WORD_W-1:0] seed;
  } request_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = OP_DRAW;
  logic [WORD_W-1:0]  seed_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [OUT_W-1:0]   random_value;

  // Generator model state
  logic [WORD_W-1:0]  lag_words [LAG_DEGREE];
  logic [IDX_W-1:0]   front_pos;
  logic [IDX_W-1:0]   rear_pos;

  request_t           request_queue [$];
  logic [OUT_W-1:0]   predicted_values [$];
  request_t           offered;
  logic [OUT_W-1:0]   want;
  int unsigned        requests_taken = 0;
  int unsigned        results_seen = 0;
  int unsigned        hold_left = 0;
  logic               hold_done = 1'b0;
  int unsigned        mismatches = 0;
  int unsigned        cycle_count = 0;

  always #1 clk_i = ~clk_i;

  additive_lagged_fibonacci_rng DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .seed_value_i   (seed_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .random_value_o (random_value)
  );

  // One additive step: front word += rear word, both indices advance with wrap.
  function automatic logic [OUT_W-1:0] lfib_draw();
    logic [WORD_W-1:0] sum;
    sum = lag_words[front_pos] + lag_words[rear_pos];
    lag_words[front_pos] = sum;
    front_pos = (front_pos == LAG_DEGREE - 1) ? '0 : front_pos + 1'b1;
    rear_pos  = (rear_pos == LAG_DEGREE - 1) ? '0 : rear_pos + 1'b1;
    return sum[WORD_W-1:1];
  endfunction

  // Park-Miller step on a word reduced into 1..2^31-2, result lowered by one.
  function automatic logic [WORD_W-1:0] minstd_next(logic [WORD_W-1:0] prev);
    longint x;
    longint hi;
    longint lo;
    x  = longint'({32'd0, prev % MINSTD_RED}) + 1;
    hi = x / SCHRAGE_Q;
    lo = x % SCHRAGE_Q;
    x  = longint'(MINSTD_MULT) * lo - SCHRAGE_R * hi;
    if (x < 0) x = x + longint'({32'd0, MINSTD_MOD});
    x = x - 1;
    if (x < 0) x = 0;
    return x[WORD_W-1:0];
  endfunction

  // Reseed: fill the table from the seed, restart the indices, burn the discard draws.
  function automatic void lfib_reseed(logic [WORD_W-1:0] seed);
    int i;
    lag_words[0] = seed;
    for (i = 1; i < LAG_DEGREE; i++) lag_words[i] = minstd_next(lag_words[i-1]);
    front_pos = LAG_SEPARATION;
    rear_pos  = '0;
    repeat (DISCARD_COUNT) void'(lfib_draw());
  endfunction

  task automatic push_request(logic op, logic [WORD_W-1:0] seed);
    request_t r;
    r.opcode = op;
    r.seed   = seed;
    request_queue.push_back(r);
  endtask

  // Mostly draws with junk in the seed field; reseeds use random or boundary seeds.
  task automatic push_random(int unsigned count);
    logic [WORD_W-1:0] s;
    repeat (count) begin
      if ($urandom_range(99) < RESEED_PCT) begin
        case ($urandom_range(9))
          0: s = '0;
          1: s = '1;
          2: s = MINSTD_RED;
          3: s = MINSTD_MOD;
          default: s = $urandom;
        endcase
        push_request(OP_RESEED, s);
      end else begin
        push_request(OP_DRAW, $urandom);
      end
    end
  endtask

  // Sampled on the falling edge so queue and handshake updates of the rising edge are settled.
  task automatic await_drain();
    @(negedge clk_i);
    while (request_queue.size() != 0 || in_valid || predicted_values.size() != 0)
      @(negedge clk_i);
  endtask

  // Sender: the item on the port is predicted when taken; a new one is
  // offered only when the port is free, so a stalled payload never moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        if (offered.opcode == OP_RESEED) lfib_reseed(offered.seed);
        else predicted_values.push_back(lfib_draw());
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (request_queue.size() != 0 &&
            ((requests_taken >= STEADY_FROM && requests_taken < STEADY_TO) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          offered = request_queue.pop_front();
          in_valid   <= 1'b1;
          opcode     <= offered.opcode;
          seed_value <= offered.seed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken value, stalls at random, and once holds off
  // for a long stretch so the block backs up into its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (predicted_values.size() == 0) begin
          $display("%0t: random_value expected none, got %h", $time, random_value);
          mismatches++;
        end else begin
          want = predicted_values.pop_front();
          if (random_value !== want) begin
            $display("%0t: random_value expected %h, got %h", $time, want, random_value);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (hold_left == 0 && !hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= STEADY_FROM && results_seen < STEADY_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    lag_words = INIT_WORDS;
    front_pos = LAG_SEPARATION;
    rear_pos  = '0;

    // Draws straight from the reset table, then reseeds at the edges of the
    // minimal-standard reduction: seeds that fold to 1, the largest folded
    // value, all ones and the top bit alone.
    repeat (4) push_request(OP_DRAW, $urandom);
    push_request(OP_RESEED, 32'h0000_0000);
    repeat (2) push_request(OP_DRAW, 32'hffff_ffff);
    push_request(OP_RESEED, 32'hffff_ffff);
    repeat (2) push_request(OP_DRAW, 32'h0000_0000);
    push_request(OP_RESEED, MINSTD_RED);
    repeat (2) push_request(OP_DRAW, $urandom);
    push_request(OP_RESEED, MINSTD_MOD);
    repeat (2) push_request(OP_DRAW, $urandom);
    push_request(OP_RESEED, MINSTD_RED - 1);
    push_request(OP_DRAW, $urandom);
    push_request(OP_RESEED, 32'h8000_0000);
    repeat (2) push_request(OP_DRAW, $urandom);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    await_drain();
    push_random(960);
    // sender pauses here until every outstanding value has been checked
    await_drain();
    push_random(970);
    await_drain();

    // a trailing reseed may keep the block busy without producing anything
    while (in_stall) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && predicted_values.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
